// ===== hw/rtl/fpp_pkg.sv =====
// Types, codes and result helpers shared by the field picture pairing block.
`timescale 1ns / 1ps

package fpp_pkg;

  // Operation codes of an input transaction
  localparam logic [1:0] OpClear  = 2'd0;
  localparam logic [1:0] OpHeader = 2'd1;
  localparam logic [1:0] OpExt    = 2'd2;

  // Picture coding types
  localparam logic [2:0] PtI = 3'd1;
  localparam logic [2:0] PtB = 3'd3;
  localparam logic [2:0] PtD = 3'd4;

  // Picture structure codes
  localparam logic [1:0] StReserved = 2'd0;
  localparam logic [1:0] StFrame    = 2'd3;

  // Display lengths in field periods
  localparam logic [2:0] Len2 = 3'd2;
  localparam logic [2:0] Len3 = 3'd3;
  localparam logic [2:0] Len4 = 3'd4;
  localparam logic [2:0] Len6 = 3'd6;

  // Result kinds
  localparam logic KindFrame = 1'b0;
  localparam logic KindError = 1'b1;

  // Configuration register indexes
  localparam int unsigned CfgIdxW     = 1;
  localparam logic [0:0]  CfgProgSeq  = 1'd0;
  localparam logic [0:0]  CfgLowDelay = 1'd1;

  // Result queue depth, must be at least two
  localparam int unsigned ResultDepth = 4;

  typedef struct packed {
    logic [2:0]  ptype;
    logic [9:0]  tref;
    logic [31:0] pos;
    logic [2:0]  len;
    logic [1:0]  structure;
    logic        tff;
    logic        rff;
    logic        prog;
  } pic_t;

  typedef struct packed {
    logic first_valid;
    pic_t first;
    logic second_valid;
    pic_t second;
  } slots_t;

  typedef struct packed {
    logic progressive_sequence;
    logic low_delay;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic        report_loss;
    logic [9:0]  temporal_ref;
    logic [2:0]  picture_type;
    logic [31:0] stream_position;
    logic [1:0]  structure;
    logic        top_first;
    logic        repeat_first;
    logic        progressive_frame;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  frame_type;
    logic [9:0]  frame_temporal_ref;
    logic [1:0]  frame_structure;
    logic        frame_top_first;
    logic        frame_repeat_first;
    logic        frame_progressive;
    logic [2:0]  field_count;
    logic [31:0] frame_position;
    logic        last;
  } out_item_t;

  // Up to two results produced by one input transaction
  typedef struct packed {
    logic [1:0] count;
    out_item_t  r0;
    out_item_t  r1;
  } res_t;

  function automatic out_item_t err_item();
    out_item_t r;
    r = '0;
    r.result_kind = KindError;
    return r;
  endfunction

  function automatic out_item_t frame_item(pic_t p);
    out_item_t r;
    r = '0;
    r.result_kind        = KindFrame;
    r.frame_type         = p.ptype;
    r.frame_temporal_ref = p.tref;
    r.frame_structure    = p.structure;
    r.frame_top_first    = p.tff;
    r.frame_repeat_first = p.rff;
    r.frame_progressive  = p.prog;
    r.field_count        = p.len;
    r.frame_position     = p.pos;
    return r;
  endfunction

endpackage

// ===== hw/rtl/fpp_in_if.sv =====
// Input channel interface: picture events.
`timescale 1ns / 1ps

interface fpp_in_if;
  logic              valid;
  logic              ready;
  fpp_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/fpp_out_if.sv =====
// Output channel interface: frame and error results.
`timescale 1ns / 1ps

interface fpp_out_if;
  logic               valid;
  logic               ready;
  fpp_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/field_picture_pairing_core.sv =====
// Top level of the field picture pairing block.
`timescale 1ns / 1ps

// Takes parsed MPEG-2 picture events (boundary clear, picture header, picture
// coding extension) and emits frame-found or error results, at most two per
// event, the final one flagged by last. An event is processed in the cycle it
// is accepted; its results are registered in the result queue. The input
// accepts one event per cycle while the result queue (ResultDepth entries)
// has two free entries; the output drains one result per cycle while ready
// is high, so events with at most one result each run at one event per
// cycle and events with two results are paced by the output. Write
// progressive_sequence (index 0) and low_delay (index 1) only while idle.
module field_picture_pairing_core #(
  parameter int unsigned ResultDepth = fpp_pkg::ResultDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fpp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [0:0]                  cfg_data_i,
  fpp_in_if.sink                      in_i,
  fpp_out_if.source                   out_o
);

  fpp_pkg::cfg_t   cfg_q;
  fpp_pkg::slots_t slots_q;
  fpp_pkg::slots_t slots_d;
  fpp_pkg::res_t   res;
  logic            fifo_ready;
  logic            in_accept;
  logic [1:0]      push_n;

  assign in_i.ready = fifo_ready;
  assign in_accept  = in_i.valid && fifo_ready;
  assign push_n     = in_accept ? res.count : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fpp_pkg::CfgProgSeq:  cfg_q.progressive_sequence <= cfg_data_i[0];
        fpp_pkg::CfgLowDelay: cfg_q.low_delay            <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= '0;
    end else if (in_accept) begin
      slots_q <= slots_d;
    end
  end

  fpp_engine u_engine (
    .cfg_i   (cfg_q),
    .slots_i (slots_q),
    .item_i  (in_i.payload),
    .slots_o (slots_d),
    .res_o   (res)
  );

  fpp_result_fifo #(
    .Depth (ResultDepth)
  ) u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .r0_i        (res.r0),
    .r1_i        (res.r1),
    .ready_o     (fifo_ready),
    .out_valid_o (out_o.valid),
    .out_item_o  (out_o.payload),
    .out_ready_i (out_o.ready)
  );

endmodule

// ===== hw/rtl/fpp_engine.sv =====
// Next-state and result logic for one picture event.
`timescale 1ns / 1ps

module fpp_engine (
  input  fpp_pkg::cfg_t     cfg_i,
  input  fpp_pkg::slots_t   slots_i,
  input  fpp_pkg::in_item_t item_i,
  output fpp_pkg::slots_t   slots_o,
  output fpp_pkg::res_t     res_o
);

  always_comb begin
    fpp_pkg::pic_t      f;
    fpp_pkg::pic_t      s;
    fpp_pkg::pic_t      p;
    logic               fv;
    logic               sv;
    logic [1:0]         n;
    fpp_pkg::out_item_t r0;
    fpp_pkg::out_item_t r1;
    logic               pair;
    logic               bad_type;

    f  = slots_i.first;
    s  = slots_i.second;
    fv = slots_i.first_valid;
    sv = slots_i.second_valid;
    n  = 2'd0;
    r0 = '0;
    r1 = '0;
    p  = '0;
    pair = 1'b0;
    bad_type = 1'b0;

    unique case (item_i.operation)
      fpp_pkg::OpClear: begin
        if (item_i.report_loss && (fv || sv)) begin
          r0 = fpp_pkg::err_item();
          n  = 2'd1;
        end
        f  = '0;
        s  = '0;
        fv = 1'b0;
        sv = 1'b0;
      end

      fpp_pkg::OpHeader: begin
        bad_type = (item_i.picture_type < fpp_pkg::PtI) ||
                   (item_i.picture_type > fpp_pkg::PtD) ||
                   (cfg_i.low_delay && item_i.picture_type == fpp_pkg::PtB);
        if (bad_type) begin
          r0 = fpp_pkg::err_item();
          n  = 2'd1;
        end else begin
          p.ptype = item_i.picture_type;
          p.tref  = item_i.temporal_ref;
          p.pos   = item_i.stream_position;
          p.len   = fpp_pkg::Len2;
          if (fv) begin
            s  = p;
            sv = 1'b1;
          end else begin
            f  = p;
            fv = 1'b1;
          end
        end
      end

      fpp_pkg::OpExt: begin
        if (item_i.structure == fpp_pkg::StReserved || !fv) begin
          r0 = fpp_pkg::err_item();
          n  = 2'd1;
        end else if (cfg_i.progressive_sequence) begin
          if (item_i.structure != fpp_pkg::StFrame || !item_i.progressive_frame ||
              (!item_i.repeat_first && item_i.top_first)) begin
            r0 = fpp_pkg::err_item();
            n  = 2'd1;
          end else begin
            if (sv) begin
              f  = s;
              s  = '0;
              sv = 1'b0;
              r0 = fpp_pkg::err_item();
              n  = 2'd1;
            end
            if (item_i.repeat_first) begin
              f.len = item_i.top_first ? fpp_pkg::Len6 : fpp_pkg::Len4;
            end
            f.structure = item_i.structure;
            f.tff       = item_i.top_first;
            f.rff       = item_i.repeat_first;
            f.prog      = item_i.progressive_frame;
            if (n == 2'd0) begin
              r0 = fpp_pkg::frame_item(f);
            end else begin
              r1 = fpp_pkg::frame_item(f);
            end
            n  = n + 2'd1;
            f  = '0;
            fv = 1'b0;
          end
        end else if (item_i.structure == fpp_pkg::StFrame) begin
          if (sv) begin
            f  = s;
            s  = '0;
            sv = 1'b0;
            r0 = fpp_pkg::err_item();
            n  = 2'd1;
          end
          if (!item_i.progressive_frame && item_i.repeat_first) begin
            if (n == 2'd0) begin
              r0 = fpp_pkg::err_item();
            end else begin
              r1 = fpp_pkg::err_item();
            end
            n = n + 2'd1;
          end else begin
            if (item_i.progressive_frame && item_i.repeat_first) begin
              f.len = fpp_pkg::Len3;
            end
            f.structure = item_i.structure;
            f.tff       = item_i.top_first;
            f.rff       = item_i.repeat_first;
            f.prog      = item_i.progressive_frame;
            if (n == 2'd0) begin
              r0 = fpp_pkg::frame_item(f);
            end else begin
              r1 = fpp_pkg::frame_item(f);
            end
            n  = n + 2'd1;
            f  = '0;
            fv = 1'b0;
          end
        end else if (item_i.top_first || item_i.repeat_first ||
                     item_i.progressive_frame) begin
          r0 = fpp_pkg::err_item();
          n  = 2'd1;
        end else if (!sv) begin
          // first field of a pair, flags are known to be zero here
          f.structure = item_i.structure;
          f.tff       = 1'b0;
          f.rff       = 1'b0;
          f.prog      = 1'b0;
        end else begin
          s.structure = item_i.structure;
          s.tff       = 1'b0;
          s.rff       = 1'b0;
          s.prog      = 1'b0;
          // low delay: refs compared without wrap
          pair = (f.tref == s.tref) ||
                 (cfg_i.low_delay && (({1'b0, f.tref} + 11'd1) < {1'b0, s.tref}));
          if (!pair || f.structure == s.structure) begin
            f  = s;
            s  = '0;
            sv = 1'b0;
            r0 = fpp_pkg::err_item();
            n  = 2'd1;
          end else begin
            s  = '0;
            sv = 1'b0;
            r0 = fpp_pkg::frame_item(f);
            n  = 2'd1;
            f  = '0;
            fv = 1'b0;
          end
        end
      end

      default: begin
      end
    endcase

    if (n == 2'd1) begin
      r0.last = 1'b1;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end

    slots_o.first        = f;
    slots_o.first_valid  = fv;
    slots_o.second       = s;
    slots_o.second_valid = sv;
    res_o.count          = n;
    res_o.r0             = r0;
    res_o.r1             = r1;
  end

endmodule

// ===== hw/rtl/fpp_result_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per transaction.
`timescale 1ns / 1ps

module fpp_result_fifo #(
  parameter int unsigned Depth = fpp_pkg::ResultDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         push_n_i,
  input  fpp_pkg::out_item_t r0_i,
  input  fpp_pkg::out_item_t r1_i,
  output logic               ready_o,
  output logic               out_valid_o,
  output fpp_pkg::out_item_t out_item_o,
  input  logic               out_ready_i
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  fpp_pkg::out_item_t slot_q [Depth];
  fpp_pkg::out_item_t slot_d [Depth];
  fpp_pkg::out_item_t shifted [Depth];
  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    count_d;
  logic [CntW-1:0]    cnt_after;
  logic               pop;

  assign out_valid_o = (count_q != '0);
  assign out_item_o  = slot_q[0];
  assign pop         = out_valid_o && out_ready_i;
  // room for the worst case of two results
  assign ready_o     = (count_q <= CntW'(Depth - 2));
  assign cnt_after   = count_q - CntW'(pop);
  assign count_d     = cnt_after + CntW'(push_n_i);

  always_comb begin
    for (int i = 0; i < Depth - 1; i++) begin
      shifted[i] = slot_q[i + 1];
    end
    shifted[Depth-1] = slot_q[Depth-1];
    for (int i = 0; i < Depth; i++) begin
      slot_d[i] = pop ? shifted[i] : slot_q[i];
      if (push_n_i != 2'd0 && CntW'(i) == cnt_after) begin
        slot_d[i] = r0_i;
      end
      if (push_n_i == 2'd2 && CntW'(i) == cnt_after + CntW'(1)) begin
        slot_d[i] = r1_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue overflow");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> count_q == $past(count_q) - CntW'($past(pop)) + CntW'($past(push_n_i)))
    else $error("result count out of step with pushes and pops");

  a_last_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !slot_q[0].last |-> count_q >= CntW'(2))
    else $error("non-final result without its successor queued");

  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && slot_q[0].result_kind == fpp_pkg::KindFrame |->
      slot_q[0].field_count == fpp_pkg::Len2 || slot_q[0].field_count == fpp_pkg::Len3 ||
      slot_q[0].field_count == fpp_pkg::Len4 || slot_q[0].field_count == fpp_pkg::Len6)
    else $error("frame with illegal field count");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && slot_q[0].result_kind == fpp_pkg::KindError |->
      slot_q[0].frame_type == '0 && slot_q[0].field_count == '0 &&
      slot_q[0].frame_position == '0)
    else $error("error result carries frame data");

endmodule

// ===== dv/field_picture_pairing_core_test.sv =====
// Self-checking testbench for field_picture_pairing_core: directed and random picture events.
`timescale 1ns / 1ps

module field_picture_pairing_core_test;

  localparam logic [1:0] OpUnused      = 2'd3;
  localparam logic [2:0] PtForbidden   = 3'd0;
  localparam logic [2:0] PtP           = 3'd2;
  localparam logic [2:0] PtFirstBad    = 3'd5;
  localparam logic [2:0] PtLastBad     = 3'd7;
  localparam logic [1:0] StTop         = 2'd1;
  localparam logic [1:0] StBottom      = 2'd2;
  localparam int         RandomItems   = 1680;
  localparam int         WatchdogLimit = 1000;

  typedef struct packed {
    logic [2:0]  ptype;
    logic [9:0]  tref;
    logic [31:0] pos;
    logic [2:0]  len;
    logic [1:0]  st;
    logic        tff;
    logic        rff;
    logic        prog;
  } slot_pic_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [fpp_pkg::CfgIdxW-1:0] cfg_idx_i;
  logic [0:0]                  cfg_data_i;

  fpp_in_if  in_if ();
  fpp_out_if out_if ();

  field_picture_pairing_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  // predictor state
  slot_pic_t pic_a, pic_b;
  logic      pic_a_valid, pic_b_valid;
  logic      cfg_prog_seq, cfg_low_delay;
  fpp_pkg::out_item_t event_results[$];
  fpp_pkg::out_item_t results_due[$];

  int mismatches;
  int quiet_cycles;
  bit tx_gaps, rx_stalls;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void emit_error();
    fpp_pkg::out_item_t r;
    r = '0;
    r.result_kind = fpp_pkg::KindError;
    event_results.push_back(r);
  endfunction

  // completes the picture in the first slot and frees the slot
  function automatic void emit_frame();
    fpp_pkg::out_item_t r;
    r = '0;
    r.result_kind        = fpp_pkg::KindFrame;
    r.frame_type         = pic_a.ptype;
    r.frame_temporal_ref = pic_a.tref;
    r.frame_structure    = pic_a.st;
    r.frame_top_first    = pic_a.tff;
    r.frame_repeat_first = pic_a.rff;
    r.frame_progressive  = pic_a.prog;
    r.field_count        = pic_a.len;
    r.frame_position     = pic_a.pos;
    event_results.push_back(r);
    pic_a       = '0;
    pic_a_valid = 1'b0;
  endfunction

  // orphan in the first slot is dropped, the waiting picture takes its place
  function automatic void promote_second();
    pic_a       = pic_b;
    pic_a_valid = 1'b1;
    pic_b       = '0;
    pic_b_valid = 1'b0;
    emit_error();
  endfunction

  function automatic slot_pic_t with_coding(slot_pic_t p, fpp_pkg::in_item_t ev);
    p.st   = ev.structure;
    p.tff  = ev.top_first;
    p.rff  = ev.repeat_first;
    p.prog = ev.progressive_frame;
    return p;
  endfunction

  function automatic void apply_extension(fpp_pkg::in_item_t ev);
    logic pairs;
    if (ev.structure == fpp_pkg::StReserved || !pic_a_valid) begin
      emit_error();
    end else if (cfg_prog_seq) begin
      if (ev.structure != fpp_pkg::StFrame || !ev.progressive_frame ||
          (!ev.repeat_first && ev.top_first)) begin
        emit_error();
      end else begin
        if (pic_b_valid) promote_second();
        if (ev.repeat_first) pic_a.len = ev.top_first ? fpp_pkg::Len6 : fpp_pkg::Len4;
        pic_a = with_coding(pic_a, ev);
        emit_frame();
      end
    end else if (ev.structure == fpp_pkg::StFrame) begin
      if (pic_b_valid) promote_second();
      if (!ev.progressive_frame && ev.repeat_first) begin
        emit_error();
      end else begin
        if (ev.progressive_frame && ev.repeat_first) pic_a.len = fpp_pkg::Len3;
        pic_a = with_coding(pic_a, ev);
        emit_frame();
      end
    end else if (ev.top_first || ev.repeat_first || ev.progressive_frame) begin
      emit_error();
    end else if (!pic_b_valid) begin
      pic_a = with_coding(pic_a, ev);
    end else begin
      pic_b = with_coding(pic_b, ev);
      // low delay: a reference more than one later also pairs, no wrap
      pairs = (pic_a.tref == pic_b.tref) ||
              (cfg_low_delay && (int'(pic_a.tref) + 1 < int'(pic_b.tref)));
      if (!pairs || pic_a.st == pic_b.st) begin
        promote_second();
      end else begin
        pic_b       = '0;
        pic_b_valid = 1'b0;
        emit_frame();
      end
    end
  endfunction

  function automatic void predict_pairing(fpp_pkg::in_item_t ev);
    logic               lost;
    slot_pic_t          p;
    fpp_pkg::out_item_t r;
    event_results.delete();
    case (ev.operation)
      fpp_pkg::OpClear: begin
        lost        = pic_a_valid || pic_b_valid;
        pic_a       = '0;
        pic_b       = '0;
        pic_a_valid = 1'b0;
        pic_b_valid = 1'b0;
        if (ev.report_loss && lost) emit_error();
      end
      fpp_pkg::OpHeader: begin
        if (ev.picture_type == PtForbidden || ev.picture_type > fpp_pkg::PtD ||
            (cfg_low_delay && ev.picture_type == fpp_pkg::PtB)) begin
          emit_error();
        end else begin
          p       = '0;
          p.ptype = ev.picture_type;
          p.tref  = ev.temporal_ref;
          p.pos   = ev.stream_position;
          p.len   = fpp_pkg::Len2;
          if (pic_a_valid) begin
            pic_b       = p;
            pic_b_valid = 1'b1;
          end else begin
            pic_a       = p;
            pic_a_valid = 1'b1;
          end
        end
      end
      fpp_pkg::OpExt: apply_extension(ev);
      default: ;
    endcase
    if (event_results.size() > 0) begin
      r      = event_results.pop_back();
      r.last = 1'b1;
      event_results.push_back(r);
    end
    foreach (event_results[i]) results_due.push_back(event_results[i]);
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    fpp_pkg::out_item_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result expected none actual %0h", $time, got);
      end else begin
        want = results_due.pop_front();
        check_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
        check_field("frame_type", 32'(want.frame_type), 32'(got.frame_type));
        check_field("frame_temporal_ref", 32'(want.frame_temporal_ref),
                    32'(got.frame_temporal_ref));
        check_field("frame_structure", 32'(want.frame_structure),
                    32'(got.frame_structure));
        check_field("frame_top_first", 32'(want.frame_top_first),
                    32'(got.frame_top_first));
        check_field("frame_repeat_first", 32'(want.frame_repeat_first),
                    32'(got.frame_repeat_first));
        check_field("frame_progressive", 32'(want.frame_progressive),
                    32'(got.frame_progressive));
        check_field("field_count", 32'(want.field_count), 32'(got.field_count));
        check_field("frame_position", want.frame_position, got.frame_position);
        check_field("last", 32'(want.last), 32'(got.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("field_picture_pairing_core: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- idling

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 50);
  endfunction

  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else begin
        out_if.ready = 1'b1;
        if (rx_stalls && $urandom_range(0, 99) < 30) stall_left = stall_len();
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic fpp_pkg::in_item_t random_event();
    logic [63:0]       bits;
    fpp_pkg::in_item_t ev;
    bits = {$urandom, $urandom};
    ev   = bits[$bits(fpp_pkg::in_item_t)-1:0];
    return ev;
  endfunction

  // unused fields keep random content
  function automatic fpp_pkg::in_item_t header_event(logic [9:0] tref, logic [2:0] ptype,
                                                     logic [31:0] pos);
    fpp_pkg::in_item_t ev;
    ev                 = random_event();
    ev.operation       = fpp_pkg::OpHeader;
    ev.temporal_ref    = tref;
    ev.picture_type    = ptype;
    ev.stream_position = pos;
    return ev;
  endfunction

  function automatic fpp_pkg::in_item_t extension_event(logic [1:0] st, logic tff,
                                                        logic rff, logic prog);
    fpp_pkg::in_item_t ev;
    ev                   = random_event();
    ev.operation         = fpp_pkg::OpExt;
    ev.structure         = st;
    ev.top_first         = tff;
    ev.repeat_first      = rff;
    ev.progressive_frame = prog;
    return ev;
  endfunction

  function automatic fpp_pkg::in_item_t clear_event(logic report);
    fpp_pkg::in_item_t ev;
    ev             = random_event();
    ev.operation   = fpp_pkg::OpClear;
    ev.report_loss = report;
    return ev;
  endfunction

  // called at a falling edge, returns at a falling edge with valid low
  task automatic send_event(fpp_pkg::in_item_t ev);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 99) < 45) ? stall_len() : 0;
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid   = 1'b1;
    in_if.payload = ev;
    do @(posedge clk_i); while (!in_if.ready);
    predict_pairing(ev);
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(logic [fpp_pkg::CfgIdxW-1:0] idx, logic val);
    wait_drained();
    // an event without results may still be in flight
    repeat (4) @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == fpp_pkg::CfgProgSeq) cfg_prog_seq = val;
    else cfg_low_delay = val;
  endtask

  function automatic logic [2:0] pick_type();
    logic [2:0] t;
    if ($urandom_range(0, 99) < 8) begin
      t = $urandom_range(0, 1) ? PtForbidden : 3'($urandom_range(PtLastBad, PtFirstBad));
    end else begin
      t = 3'($urandom_range(fpp_pkg::PtD, fpp_pkg::PtI));
      if (cfg_low_delay && t == fpp_pkg::PtB && $urandom_range(0, 3) != 0) t = PtP;
    end
    return t;
  endfunction

  function automatic logic [1:0] pick_field();
    return $urandom_range(0, 1) ? StTop : StBottom;
  endfunction

  // one well-formed or broken picture sequence, or noise
  task automatic send_picture_unit(output int n);
    int         pick, r;
    logic [9:0] t, t2;
    logic [1:0] st;
    logic       prog;
    pick = $urandom_range(0, 99);
    t    = 10'($urandom);
    if (pick < 40) begin
      prog = cfg_prog_seq ? ($urandom_range(0, 9) != 0) : 1'($urandom);
      send_event(header_event(t, pick_type(), $urandom));
      send_event(extension_event(fpp_pkg::StFrame, 1'($urandom), 1'($urandom), prog));
      n = 2;
    end else if (pick < 70) begin
      st = pick_field();
      send_event(header_event(t, pick_type(), $urandom));
      if ($urandom_range(0, 9) == 0)
        send_event(extension_event(st, 1'($urandom), 1'($urandom), 1'($urandom)));
      else
        send_event(extension_event(st, 1'b0, 1'b0, 1'b0));
      r = $urandom_range(0, 99);
      if (r < 65) t2 = t;
      else if (r < 85) t2 = t + 10'($urandom_range(1, 3));
      else t2 = 10'($urandom);
      send_event(header_event(t2, pick_type(), $urandom));
      if ($urandom_range(0, 99) < 85) st = (st == StTop) ? StBottom : StTop;
      if ($urandom_range(0, 9) == 0)
        send_event(extension_event(st, 1'($urandom), 1'($urandom), 1'($urandom)));
      else
        send_event(extension_event(st, 1'b0, 1'b0, 1'b0));
      n = 4;
    end else if (pick < 80) begin
      // stacked headers: the second slot is overwritten or shifted in
      send_event(header_event(t, pick_type(), $urandom));
      send_event(header_event(10'($urandom), pick_type(), $urandom));
      n = 2;
      if ($urandom_range(0, 2) == 0) begin
        send_event(header_event(10'($urandom), pick_type(), $urandom));
        n++;
      end
      st   = 2'($urandom_range(fpp_pkg::StFrame, StTop));
      prog = cfg_prog_seq ? ($urandom_range(0, 4) != 0) : 1'($urandom);
      send_event(extension_event(st, 1'($urandom), 1'($urandom), prog));
      n++;
    end else if (pick < 87) begin
      send_event(clear_event(1'($urandom)));
      n = 1;
    end else begin
      send_event(random_event());
      n = 1;
    end
  endtask

  task automatic run_random(int count);
    int         sent, n, mode_until;
    logic [1:0] mode;
    sent       = 0;
    mode_until = 0;
    while (sent < count) begin
      if (sent >= mode_until) begin
        mode       = 2'($urandom);
        tx_gaps    = mode[0];
        rx_stalls  = mode[1];
        mode_until = sent + $urandom_range(20, 80);
      end
      send_picture_unit(n);
      sent += n;
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_default_rules();
    fpp_pkg::in_item_t odd;
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    send_event(clear_event(1'b1));                       // nothing pending, silent
    send_event(header_event(10'd0, fpp_pkg::PtI, 32'h0000_0000));
    send_event(extension_event(fpp_pkg::StFrame, 1'b0, 1'b0, 1'b0));
    send_event(header_event(10'h3ff, PtP, 32'hffff_ffff));
    send_event(extension_event(fpp_pkg::StFrame, 1'b1, 1'b1, 1'b1));  // three fields
    send_event(header_event(10'd5, PtForbidden, $urandom));
    send_event(header_event(10'd5, PtLastBad, $urandom));
    send_event(extension_event(fpp_pkg::StFrame, 1'b0, 1'b0, 1'b0));  // no pending picture
    send_event(header_event(10'd10, fpp_pkg::PtB, 32'h1234_5678));
    send_event(extension_event(fpp_pkg::StReserved, 1'b0, 1'b0, 1'b0));
    send_event(extension_event(fpp_pkg::StFrame, 1'b0, 1'b1, 1'b0));  // interlaced repeat
    send_event(extension_event(StTop, 1'b0, 1'b0, 1'b0));
    send_event(header_event(10'd10, fpp_pkg::PtB, 32'h8765_4321));
    send_event(extension_event(StBottom, 1'b0, 1'b0, 1'b0)); // pairs
    send_event(header_event(10'd20, fpp_pkg::PtD, $urandom));
    send_event(extension_event(StTop, 1'b1, 1'b0, 1'b0));    // flags on a field
    send_event(header_event(10'd21, PtP, $urandom));
    send_event(extension_event(fpp_pkg::StFrame, 1'b0, 1'b0, 1'b0));  // shift, then frame
    send_event(header_event(10'd30, fpp_pkg::PtI, $urandom));
    send_event(extension_event(StTop, 1'b0, 1'b0, 1'b0));
    send_event(header_event(10'd31, PtP, $urandom));
    send_event(extension_event(StBottom, 1'b0, 1'b0, 1'b0)); // no pair, shift
    odd           = header_event(10'd1, fpp_pkg::PtI, $urandom);
    odd.operation = OpUnused;
    send_event(odd);
    send_event(clear_event(1'b1));
    send_event(clear_event(1'b0));
  endtask

  task automatic test_low_delay_rules();
    write_register(fpp_pkg::CfgLowDelay, 1'b1);
    send_event(header_event(10'd7, fpp_pkg::PtB, $urandom));
    send_event(header_event(10'd5, PtP, $urandom));
    send_event(extension_event(StTop, 1'b0, 1'b0, 1'b0));
    send_event(header_event(10'd7, PtP, $urandom));
    send_event(extension_event(StBottom, 1'b0, 1'b0, 1'b0)); // later ref pairs
    send_event(header_event(10'd5, fpp_pkg::PtI, $urandom));
    send_event(extension_event(StTop, 1'b0, 1'b0, 1'b0));
    send_event(header_event(10'd6, PtP, $urandom));
    send_event(extension_event(StBottom, 1'b0, 1'b0, 1'b0)); // ref + 1 does not
  endtask

  task automatic test_progressive_rules();
    write_register(fpp_pkg::CfgLowDelay, 1'b0);
    write_register(fpp_pkg::CfgProgSeq, 1'b1);
    send_event(header_event(10'd40, fpp_pkg::PtI, $urandom));
    send_event(extension_event(fpp_pkg::StFrame, 1'b1, 1'b1, 1'b1));  // six fields
    send_event(header_event(10'd41, PtP, $urandom));
    send_event(extension_event(fpp_pkg::StFrame, 1'b0, 1'b1, 1'b1));  // four fields
    send_event(header_event(10'd42, fpp_pkg::PtB, $urandom));
    send_event(extension_event(fpp_pkg::StFrame, 1'b1, 1'b0, 1'b1));  // top first, no repeat
    send_event(extension_event(StTop, 1'b0, 1'b0, 1'b1));
    send_event(header_event(10'd43, PtP, $urandom));
    send_event(extension_event(fpp_pkg::StFrame, 1'b0, 1'b0, 1'b1));  // shift, then frame
  endtask

  task automatic test_random_configs();
    int k;
    for (k = 0; k < 6; k++) begin
      if (k < 4) begin
        write_register(fpp_pkg::CfgProgSeq, k[1]);
        write_register(fpp_pkg::CfgLowDelay, k[0]);
      end else begin
        write_register(fpp_pkg::CfgProgSeq, 1'($urandom));
        write_register(fpp_pkg::CfgLowDelay, 1'($urandom));
      end
      run_random(RandomItems / 6);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    in_if.valid   = 1'b0;
    in_if.payload = '0;
    tx_gaps       = 1'b0;
    rx_stalls     = 1'b0;
    mismatches    = 0;
    quiet_cycles  = 0;
    pic_a         = '0;
    pic_b         = '0;
    pic_a_valid   = 1'b0;
    pic_b_valid   = 1'b0;
    cfg_prog_seq  = 1'b0;
    cfg_low_delay = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_rules();
    test_low_delay_rules();
    test_progressive_rules();
    test_random_configs();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("field_picture_pairing_core: match");
    end else begin
      $display("field_picture_pairing_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/fpp_pkg.sv
hw/rtl/fpp_in_if.sv
hw/rtl/fpp_out_if.sv
hw/rtl/fpp_engine.sv
hw/rtl/fpp_result_fifo.sv
hw/rtl/field_picture_pairing_core.sv
dv/field_picture_pairing_core_test.sv
